/* rtl/prlod_pkg.sv */
// Package for the pairwise recombination / LOD block.
// Holds the back-end state type and fixed arithmetic constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prlod_pkg;

  localparam int LG_FRAC = 24;                    // fraction bits of log2
  localparam logic [22:0] LOG10_2_Q24 = 23'd5050445;
  localparam logic [18:0] LOD_MAX = 19'd524287;
  localparam int RF_W  = 17;
  localparam int OUT_CNT_W = 13;
  localparam int LOD_W = 19;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIV,
    BK_LSTART,
    BK_LWAIT,
    BK_ACC,
    BK_CLAMP,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_RND,
    BK_FIN
  } bk_state_t;

endpackage
`default_nettype wire

/* rtl/prlod_front.sv */
// Front end: counts informative and recombinant words for one marker pair.
// On the last word it hands the counts to the queue. Uses prlod_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prlod_front
  import prlod_pkg::*;
#(
  parameter int MAX_IND = 4096,
  parameter int CNT_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       geno_first,
  input  wire logic [1:0]       geno_second,
  input  wire logic             last,
  output logic                  push,
  output logic [2*CNT_W-1:0]    push_data,
  input  wire logic             q_ready
);

  logic [CNT_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic             take;

  assign in_ready = q_ready;

  always_comb begin
    take  = in_valid && in_ready;
    a_nxt = a_r;
    b_nxt = b_r;
    if ((geno_first != 2'd0) && (geno_second != 2'd0) &&
        ({1'b0, a_r} < (CNT_W+1)'(MAX_IND))) begin
      a_nxt = a_r + CNT_W'(1);
      if (geno_first != geno_second) b_nxt = b_r + CNT_W'(1);
    end
    push      = take && last;
    push_data = {a_nxt, b_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
    end else if (take) begin
      a_r <= last ? '0 : a_nxt;
      b_r <= last ? '0 : b_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/prlod_fifo.sv */
// Two-entry queue between front and back ends.
// Holds count pairs; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module prlod_fifo #(
  parameter int W = 26
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              push_ready,
  input  wire logic         pop,
  output logic              pop_valid,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && push_ready) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && push_ready) wp_r <= ~wp_r;
      if (pop && pop_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && push_ready) - 2'(pop && pop_valid);
    end
  end

endmodule
`default_nettype wire

/* rtl/prlod_log2.sv */
// Serial log2 unit: integer part from the leading one, 24 fraction bits
// by repeated squaring, one bit per cycle. Uses prlod_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prlod_log2
  import prlod_pkg::*;
#(
  parameter int CNT_W = 13,
  parameter int K_W = 5
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [CNT_W-1:0]       n,
  output logic                        done,
  output logic [K_W+LG_FRAC-1:0]      lg
);

  logic [K_W-1:0]     k, k_r;
  logic [30:0]        x_r;
  logic [LG_FRAC-1:0] frac_r;
  logic [4:0]         step_r;
  logic               busy_r;
  logic [61:0]        sq;
  logic [31:0]        t;

  always_comb begin
    k = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n[i]) k = K_W'(i);
    end
    sq = 62'(x_r) * 62'(x_r);
    t  = sq[61:30];
  end

  assign lg = {k_r, frac_r};

  always_ff @(posedge clk) begin
    if (start) begin
      k_r    <= k;
      x_r    <= 31'({n, 30'b0} >> k);
      frac_r <= '0;
    end else if (busy_r) begin
      frac_r <= {frac_r[LG_FRAC-2:0], t[31]};
      x_r    <= t[31] ? t[31:1] : t[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'(LG_FRAC - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/prlod_back.sv */
// Back end: serial divide for rf, three n*log2(n) terms through the shared
// log2 unit, scaling by log10(2), result register. Uses prlod_pkg, prlod_log2.
`timescale 1ns / 1ps
`default_nettype none
module prlod_back
  import prlod_pkg::*;
#(
  parameter int CNT_W = 13
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire logic [2*CNT_W-1:0]   q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OUT_CNT_W-1:0]      out_informative,
  output logic [OUT_CNT_W-1:0]      out_recombinant,
  output logic [RF_W-1:0]           out_rf_frac,
  output logic [LOD_W-1:0]          out_lod_q8,
  output logic                      out_no_data
);

  localparam int K_W    = $clog2(CNT_W) + 1;
  localparam int LG_W   = K_W + LG_FRAC;
  localparam int PROD_W = CNT_W + LG_W;
  localparam int SUM_A  = PROD_W + 2;
  localparam int SUM_W  = (SUM_A > 42) ? SUM_A : 42;
  localparam int HI_W   = SUM_W - 1 - LG_FRAC;
  localparam int TOT_W  = SUM_W + 23;
  localparam int NUM_W  = CNT_W + 17;
  localparam int C_W    = $clog2(NUM_W + 1);

  bk_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        a_r, b_r, c_r, opn;
  logic [NUM_W-1:0]        num_r, q_r;
  logic [CNT_W:0]          rem_r, rem_sh;
  logic [C_W-1:0]          cnt_r;
  logic [1:0]              idx_r;
  logic [PROD_W-1:0]       prod_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [23+LG_FRAC-1:0]   plo_r;
  logic [HI_W+23-1:0]      phi_r;
  logic [TOT_W-1:0]        tot;
  logic [TOT_W-41:0]       lodf_r;
  logic                    lg_start, lg_done;
  logic [LG_W-1:0]         lg;
  logic                    fin_ok;

  prlod_log2 #(.CNT_W(CNT_W), .K_W(K_W)) u_log2 (
    .clk(clk), .rst_n(rst_n), .start(lg_start), .n(opn), .done(lg_done), .lg(lg)
  );

  always_comb begin
    unique case (idx_r)
      2'd0:    opn = b_r;
      2'd1:    opn = c_r;
      default: opn = a_r;
    endcase
    rem_sh = {rem_r[CNT_W-1:0], num_r[NUM_W-1]};
    tot    = (TOT_W'(phi_r) << LG_FRAC) + TOT_W'(plo_r) + (TOT_W'(1) << 39);
    fin_ok = !out_valid || out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    lg_start  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = (q_data[2*CNT_W-1:CNT_W] == '0) ? BK_FIN : BK_DIV;
        end
      end
      BK_DIV:    if (cnt_r == C_W'(NUM_W - 1)) state_nxt = BK_LSTART;
      BK_LSTART: begin
        lg_start  = (opn != '0);
        state_nxt = (opn != '0) ? BK_LWAIT : BK_ACC;
      end
      BK_LWAIT:  if (lg_done) state_nxt = BK_ACC;
      BK_ACC:    state_nxt = (idx_r == 2'd2) ? BK_CLAMP : BK_LSTART;
      BK_CLAMP:  state_nxt = BK_MUL_LO;
      BK_MUL_LO: state_nxt = BK_MUL_HI;
      BK_MUL_HI: state_nxt = BK_RND;
      BK_RND:    state_nxt = BK_FIN;
      BK_FIN:    if (fin_ok) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        a_r    <= q_data[2*CNT_W-1:CNT_W];
        b_r    <= q_data[CNT_W-1:0];
        c_r    <= q_data[2*CNT_W-1:CNT_W] - q_data[CNT_W-1:0];
        // b * 2^16 + a/2, so the quotient comes out rounded half up
        num_r  <= NUM_W'({q_data[CNT_W-1:0], 16'b0}) +
                  NUM_W'(q_data[2*CNT_W-1:CNT_W+1]);
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= '0;
        idx_r  <= 2'd0;
        sum_r  <= SUM_W'(q_data[2*CNT_W-1:CNT_W]) <<< LG_FRAC;
        lodf_r <= '0;
      end
      BK_DIV: begin
        num_r <= num_r << 1;
        cnt_r <= cnt_r + C_W'(1);
        if (rem_sh >= {1'b0, a_r}) begin
          rem_r <= rem_sh - {1'b0, a_r};
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
      end
      BK_LSTART: prod_r <= '0;
      BK_LWAIT:  if (lg_done) prod_r <= PROD_W'(opn) * PROD_W'(lg);
      BK_ACC: begin
        if (idx_r == 2'd2) sum_r <= sum_r - $signed(SUM_W'(prod_r));
        else               sum_r <= sum_r + $signed(SUM_W'(prod_r));
        idx_r <= idx_r + 2'd1;
      end
      BK_CLAMP:  if (sum_r < 0) sum_r <= '0;
      BK_MUL_LO: plo_r <= (23+LG_FRAC)'(sum_r[LG_FRAC-1:0]) * (23+LG_FRAC)'(LOG10_2_Q24);
      BK_MUL_HI: phi_r <= (HI_W+23)'(sum_r[SUM_W-2:LG_FRAC]) * (HI_W+23)'(LOG10_2_Q24);
      BK_RND:    lodf_r <= tot[TOT_W-1:40];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state_r == BK_FIN && fin_ok) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_FIN && fin_ok) begin
      out_informative <= OUT_CNT_W'(a_r);
      out_recombinant <= OUT_CNT_W'(b_r);
      out_no_data     <= (a_r == '0);
      out_rf_frac     <= (a_r == '0) ? '0 : q_r[RF_W-1:0];
      out_lod_q8      <= (lodf_r > (TOT_W-40)'(LOD_MAX)) ? LOD_MAX : LOD_W'(lodf_r);
    end
  end

endmodule
`default_nettype wire

/* rtl/pairwise_recombination_lod.sv */
// Pairwise recombination fraction and LOD for one marker pair.
// Front takes one word per cycle while the queue has room. After a pair's last word
// the back end pops it, divides, forms three log2 terms (skipped for a zero count),
// scales and rounds, then loads the result; with nothing typed it goes to the result.
// A two-entry queue lets counting continue while the back end works.
// Synchronous active-low reset clears counts, queue, back-end state and out_valid.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_recombination_lod
  import prlod_pkg::*;
#(
  parameter int MAX_IND = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_geno_first,
  input  wire logic [1:0]  in_geno_second,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [12:0]      out_informative,
  output logic [12:0]      out_recombinant,
  output logic [16:0]      out_rf_frac,
  output logic [18:0]      out_lod_q8,
  output logic             out_no_data
);

  localparam int CNT_W = $clog2(MAX_IND + 1);

  logic               push, q_ready, q_valid, q_pop;
  logic [2*CNT_W-1:0] push_data, q_data;

  prlod_front #(.MAX_IND(MAX_IND), .CNT_W(CNT_W)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .geno_first(in_geno_first), .geno_second(in_geno_second), .last(in_last),
    .push(push), .push_data(push_data), .q_ready(q_ready)
  );

  prlod_fifo #(.W(2*CNT_W)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .push_ready(q_ready), .pop(q_pop), .pop_valid(q_valid), .pop_data(q_data)
  );

  prlod_back #(.CNT_W(CNT_W)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_informative(out_informative), .out_recombinant(out_recombinant),
    .out_rf_frac(out_rf_frac), .out_lod_q8(out_lod_q8), .out_no_data(out_no_data)
  );

endmodule
`default_nettype wire

/* sim/pairwise_recombination_lod_tb.sv */
// Testbench for pairwise_recombination_lod: drives genotype words, predicts the
// per-pair counts, rf and LOD, and checks each result word. Depends on prlod_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_recombination_lod_tb
  import prlod_pkg::*;
();

  localparam int MAX_IND_TB = 4096;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] G_MISS = 2'd0;
  localparam logic [1:0] G_AA = 2'd1;
  localparam logic [1:0] G_AB = 2'd2;
  localparam logic [1:0] G_THREE = 2'd3;

  typedef struct packed {
    logic [12:0] informative;
    logic [12:0] recombinant;
    logic [16:0] rf_frac;
    logic [18:0] lod_q8;
    logic        no_data;
  } pair_result_t;

  int fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  class linkage_scoreboard;
    int unsigned n_typed;
    int unsigned n_recomb;
    pair_result_t pending[$];

    function new();
      n_typed = 0;
      n_recomb = 0;
    endfunction

    // log2 in Q.24, leading one plus repeated squaring of the mantissa
    function automatic longint unsigned log2_q24(int unsigned n);
      int unsigned k;
      longint unsigned x;
      longint unsigned fr;
      k = 0;
      fr = 0;
      while (k < 31 && (n >> (k + 1)) != 0) k++;
      if (k > 30) k = 30;
      x = (longint'(n) << (30 - k)) & 64'h7FFF_FFFF;
      for (int i = 0; i < 24; i++) begin
        x = (x * x) >> 30;
        fr = fr << 1;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          fr = fr | 1;
        end
      end
      return (longint'(k) << 24) | fr;
    endfunction

    function automatic longint nlogn(int unsigned n);
      if (n == 0) return 0;
      return longint'(n) * longint'(log2_q24(n));
    endfunction

    function void note_word(logic [1:0] g1, logic [1:0] g2, logic lst);
      pair_result_t r;
      longint sum;
      longint unsigned prod, lod, rf;
      if (g1 != 0 && g2 != 0 && n_typed < MAX_IND_TB) begin
        n_typed++;
        if (g1 != g2) n_recomb++;
      end
      if (!lst) return;
      rf = 0;
      lod = 0;
      if (n_typed != 0) begin
        rf = ((longint'(n_recomb) << 16) + (n_typed >> 1)) / n_typed;
        sum = nlogn(n_recomb) + nlogn(n_typed - n_recomb) - nlogn(n_typed)
            + (longint'(n_typed) << 24);
        if (sum < 0) sum = 0;
        prod = longint'(sum) * 64'd5050445;
        lod = (prod + (64'd1 << 39)) >> 40;
        if (lod > LOD_MAX) lod = LOD_MAX;
      end
      r.informative = n_typed[12:0];
      r.recombinant = n_recomb[12:0];
      r.rf_frac = rf[16:0];
      r.lod_q8 = lod[18:0];
      r.no_data = (n_typed == 0);
      pending.push_back(r);
      n_typed = 0;
      n_recomb = 0;
    endfunction

    task check_result(pair_result_t got);
      pair_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.informative !== e.informative)
        report_mismatch($sformatf("informative %0d exp %0d", got.informative, e.informative));
      if (got.recombinant !== e.recombinant)
        report_mismatch($sformatf("recombinant %0d exp %0d", got.recombinant, e.recombinant));
      if (got.rf_frac !== e.rf_frac)
        report_mismatch($sformatf("rf_frac %0d exp %0d", got.rf_frac, e.rf_frac));
      if (got.lod_q8 !== e.lod_q8)
        report_mismatch($sformatf("lod_q8 %0d exp %0d", got.lod_q8, e.lod_q8));
      if (got.no_data !== e.no_data)
        report_mismatch($sformatf("no_data %0b exp %0b", got.no_data, e.no_data));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_geno_first = 2'd0;
  logic [1:0] in_geno_second = 2'd0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [12:0] out_informative;
  logic [12:0] out_recombinant;
  logic [16:0] out_rf_frac;
  logic [18:0] out_lod_q8;
  logic out_no_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  linkage_scoreboard sb = new();

  always #1 clk = ~clk;

  pairwise_recombination_lod dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_geno_first(in_geno_first), .in_geno_second(in_geno_second), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_informative(out_informative), .out_recombinant(out_recombinant),
    .out_rf_frac(out_rf_frac), .out_lod_q8(out_lod_q8), .out_no_data(out_no_data)
  );

  // receiver side: random stall, check each accepted word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_informative, out_recombinant, out_rf_frac, out_lod_q8, out_no_data});
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one word; valid held until accepted, optional idle gap before it
  task automatic send_word(input logic [1:0] g1, input logic [1:0] g2, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_geno_first <= g1;
    in_geno_second <= g2;
    in_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(g1, g2, lst);
  endtask

  function automatic logic [1:0] rand_geno();
    int p;
    p = $urandom_range(99);
    if (p < 10) return G_MISS;
    if (p < 14) return G_THREE;
    return (p < 57) ? G_AA : G_AB;
  endfunction

  // one marker pair with a chosen linkage tightness
  task automatic send_pair(input int n);
    int recomb_pct;
    logic [1:0] g1, g2;
    recomb_pct = $urandom_range(100);
    for (int i = 0; i < n; i++) begin
      g1 = rand_geno();
      g2 = g1;
      if ($urandom_range(99) < recomb_pct) g2 = (g1 == G_AA) ? G_AB : G_AA;
      if ($urandom_range(99) < 8) g2 = rand_geno();
      send_word(g1, g2, i == n - 1);
    end
  endtask

  initial begin
    int words;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pairs, all missing, extremes of codes and of rf
    send_word(G_MISS, G_MISS, 1'b1);
    send_word(G_MISS, G_AA, 1'b0);
    send_word(G_AB, G_MISS, 1'b1);
    send_word(G_AA, G_AA, 1'b1);
    send_word(G_AA, G_AB, 1'b1);
    send_word(G_THREE, G_THREE, 1'b0);
    send_word(G_THREE, G_AA, 1'b0);
    send_word(G_AB, G_THREE, 1'b1);
    send_word(G_AB, G_AB, 1'b0);
    send_word(G_AA, G_AB, 1'b0);
    send_word(G_AB, G_AA, 1'b0);
    send_word(G_AA, G_AA, 1'b1);
    send_word(G_AB, G_AA, 1'b0);
    send_word(G_AB, G_AA, 1'b0);
    send_word(G_AB, G_AA, 1'b1);

    words = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 67) : 0;
      recv_stall_pct = (ph == 2) ? 67 : ((ph == 3) ? 22 : 0);
      while (words < 475 * (ph + 1)) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
        send_pair(n);
        words += n;
      end
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
rtl/prlod_pkg.sv
rtl/prlod_front.sv
rtl/prlod_fifo.sv
rtl/prlod_log2.sv
rtl/prlod_back.sv
rtl/pairwise_recombination_lod.sv
sim/pairwise_recombination_lod_tb.sv
